// File: rtl/core/cfr_pkg.sv
// cfr_pkg: shared types, constants and the byte-wide crc-8 update
// for the crc-8 checked frame receiver; no dependencies
package cfr_pkg;

  localparam int unsigned PAYLOAD_SLOTS = 8;
  localparam int unsigned IDX_W         = $clog2(PAYLOAD_SLOTS);
  localparam int unsigned LEN_W         = 4;
  localparam int unsigned DEF_MAX_PAYLOAD = 8;
  localparam logic [7:0]  MARKER_RESET  = 8'hAA;
  localparam logic [7:0]  CRC_POLY      = 8'h8C;
  localparam logic [7:0]  CRC_INIT      = 8'h00;

  // one received byte held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } rx_beat_t;

  // one finished frame
  typedef struct packed {
    logic                              crc_match;
    logic [LEN_W-1:0]                  length;
    logic [PAYLOAD_SLOTS-1:0][7:0]     payload;
  } frame_t;

  // reflected crc-8, lsb first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
    logic [7:0] crc;
    logic [7:0] b;
    logic       fb;
    crc = crc_in;
    b   = data_in;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[0] ^ b[0];
      crc = {1'b0, crc[7:1]};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
      b = {1'b0, b[7:1]};
    end
    return crc;
  endfunction

endpackage

// File: rtl/core/crc8_checked_frame_receiver.sv
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------
//  rx in    | in_valid_i / in_stall_o  | rx_byte_i
//  frame out| out_valid_o / out_stall_i| crc_match_o, payload_length_o, payload_k_o
//  config   | cfg_we_i                 | cfg_wdata_i (start marker)
//
// one byte per cycle unless a stalled result holds the input; after its last beat
// a frame result passes the input register, then the deframer writes the result register
// asynchronous active-low reset puts the deframer in hunt with marker 0xAA
// a stalled result holds; while it waits the held input byte is not taken,
// so the input stalls as soon as its register is occupied
// depends on cfr_pkg, cfr_in_reg, cfr_engine
module crc8_checked_frame_receiver
  import cfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       crc_match_o,
  output logic [3:0] payload_length_o,
  output logic [7:0] payload_0_o,
  output logic [7:0] payload_1_o,
  output logic [7:0] payload_2_o,
  output logic [7:0] payload_3_o,
  output logic [7:0] payload_4_o,
  output logic [7:0] payload_5_o,
  output logic [7:0] payload_6_o,
  output logic [7:0] payload_7_o
);

  rx_beat_t beat;
  logic     take;
  frame_t   frame;

  // input register
  cfr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (take),
    .beat_o     (beat)
  );

  // deframer and result register
  cfr_engine #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .beat_i      (beat),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_o     (frame)
  );

  // result fields
  assign crc_match_o      = frame.crc_match;
  assign payload_length_o = frame.length;
  assign payload_0_o      = frame.payload[0];
  assign payload_1_o      = frame.payload[1];
  assign payload_2_o      = frame.payload[2];
  assign payload_3_o      = frame.payload[3];
  assign payload_4_o      = frame.payload[4];
  assign payload_5_o      = frame.payload[5];
  assign payload_6_o      = frame.payload[6];
  assign payload_7_o      = frame.payload[7];

  // a new result only follows a byte taken from the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(take))
    else $error("result appeared without a byte being taken");

  // declared length never exceeds the configured maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (payload_length_o <= LEN_W'(MAX_PAYLOAD)))
    else $error("result length above maximum payload");

  // with a zero length, slots 0 and 7 read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_length_o == 4'd0) |->
      (payload_0_o == 8'h00 && payload_7_o == 8'h00))
    else $error("unused payload slot not cleared");

endmodule

// File: rtl/core/cfr_in_reg.sv
// cfr_in_reg: input register for received bytes
// depends on cfr_pkg
module cfr_in_reg
  import cfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       take_i,
  output rx_beat_t   beat_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       load;

  // hold while the engine cannot take the held beat
  assign in_stall_o = valid_q & ~take_i;
  assign load       = ~in_stall_o;

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  // byte, no reset needed
  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      data_q <= rx_byte_i;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.data  = data_q;

endmodule

// File: rtl/core/cfr_engine.sv
// cfr_engine: deframing state machine, crc-8, payload store and result register
// depends on cfr_pkg
module cfr_engine
  import cfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  rx_beat_t beat_i,
  output logic     take_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output frame_t   frame_o
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_CSUM,
    PH_DATA
  } phase_e;

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  phase_e                         phase_q, phase_d;
  logic [IDX_W-1:0]               idx_q, idx_d;
  logic [LEN_W-1:0]               len_q, len_d;
  logic [7:0]                     csum_q, csum_d;
  logic [7:0]                     crc_q, crc_d;
  logic [7:0]                     marker_q;
  logic [PAYLOAD_SLOTS-1:0][7:0]  store_q, store_d;
  logic                           emit;
  logic                           out_valid_q, out_valid_d;
  frame_t                         frame_q, frame_d;
  logic [7:0]                     b;
  logic [7:0]                     crc_next;

  assign b        = beat_i.data;
  assign crc_next = crc8_update(crc_q, b);

  // take the held beat when the result slot is free or being drained
  assign take_o = beat_i.valid & (~out_valid_q | ~out_stall_i);

  // next frame state and result
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    len_d   = len_q;
    csum_d  = csum_q;
    crc_d   = crc_q;
    store_d = store_q;
    emit    = 1'b0;
    frame_d = frame_q;
    if (take_o) begin
      case (phase_q)
        PH_HUNT: begin
          if (b == marker_q) begin
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b > MaxLen) begin
            phase_d = PH_HUNT;
          end else begin
            len_d   = b[LEN_W-1:0];
            crc_d   = CRC_INIT;
            idx_d   = '0;
            phase_d = PH_CSUM;
          end
        end
        PH_CSUM: begin
          csum_d = b;
          if (len_q == '0) begin
            emit    = 1'b1;
            phase_d = PH_HUNT;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          store_d[idx_q] = b;
          crc_d          = crc_next;
          idx_d          = idx_q + 1'b1;
          if (LEN_W'(idx_q) + 1'b1 == len_q) begin
            emit    = 1'b1;
            phase_d = PH_HUNT;
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
    // build the result from the updated state, unused slots read zero
    if (emit) begin
      frame_d.crc_match = (crc_d == csum_d);
      frame_d.length    = len_q;
      for (int k = 0; k < PAYLOAD_SLOTS; k++) begin
        frame_d.payload[k] = (LEN_W'(k) < len_q) ? store_d[k] : 8'h00;
      end
    end
  end

  // result slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state and marker register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      idx_q       <= '0;
      len_q       <= '0;
      csum_q      <= '0;
      crc_q       <= CRC_INIT;
      marker_q    <= MARKER_RESET;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      csum_q      <= csum_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        marker_q <= cfg_wdata_i;
      end
    end
  end

  // payload store and result register
  always_ff @(posedge clk_i) begin
    store_q <= store_d;
    frame_q <= frame_d;
  end

  assign out_valid_o = out_valid_q;
  assign frame_o     = frame_q;

endmodule

// File: verif/crc8_frame_checker.sv
// crc8_frame_checker: watches the rx and frame channels of the crc-8 frame receiver,
// predicts each finished frame and compares it field by field
// depends on cfr_pkg
module crc8_frame_checker
  import cfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_o,
  input  logic       out_stall_i,
  input  logic       crc_match_o,
  input  logic [3:0] payload_length_o,
  input  logic [7:0] payload_0_o,
  input  logic [7:0] payload_1_o,
  input  logic [7:0] payload_2_o,
  input  logic [7:0] payload_3_o,
  input  logic [7:0] payload_4_o,
  input  logic [7:0] payload_5_o,
  input  logic [7:0] payload_6_o,
  input  logic [7:0] payload_7_o,
  output int         mismatch_count_o,
  output int         frames_pending_o
);

  // deframer phases: hunt, length, checksum, then one per payload beat
  localparam int PH_HUNT = 0;
  localparam int PH_LEN  = 1;
  localparam int PH_CSUM = 2;
  localparam int PH_DATA = 3;

  // shadow of the deframer
  logic [7:0]       marker;
  int               phase;
  logic [LEN_W-1:0] frame_len;
  logic [7:0]       frame_csum;
  logic [7:0]       crc_acc;
  logic [7:0]       body [PAYLOAD_SLOTS];
  frame_t           frames_due [$];
  int               frames_seen;

  // reflected crc-8 over one byte, lsb first
  function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ ((r[0] ^ data[i]) ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("frame %0d: %s got 0x%0h want 0x%0h", frames_seen, what, got, want);
    mismatch_count_o++;
  endtask

  // queue the frame the deframer should emit now
  task automatic close_frame();
    frame_t f;
    f.crc_match = (crc_acc == frame_csum);
    f.length    = frame_len;
    for (int k = 0; k < PAYLOAD_SLOTS; k++) begin
      f.payload[k] = (k < frame_len) ? body[k] : 8'h00;
    end
    frames_due.push_back(f);
    phase = PH_HUNT;
  endtask

  // advance the shadow deframer by one accepted rx beat
  task automatic take_beat(input logic [7:0] b);
    int idx;
    if (phase == PH_HUNT) begin
      if (b == marker) phase = PH_LEN;
    end else if (phase == PH_LEN) begin
      if (b > MAX_PAYLOAD) begin
        phase = PH_HUNT;
      end else begin
        frame_len = b[LEN_W-1:0];
        crc_acc   = CRC_INIT;
        phase     = PH_CSUM;
      end
    end else if (phase == PH_CSUM) begin
      frame_csum = b;
      if (frame_len == 0) close_frame();
      else phase = PH_DATA;
    end else begin
      idx       = phase - PH_DATA;
      body[idx] = b;
      crc_acc   = crc_fold(crc_acc, b);
      if (idx + 1 == frame_len) close_frame();
      else phase++;
    end
  endtask

  // compare one accepted frame beat with the oldest prediction
  task automatic check_frame();
    frame_t     want;
    logic [7:0] got [PAYLOAD_SLOTS];
    got = '{payload_0_o, payload_1_o, payload_2_o, payload_3_o,
            payload_4_o, payload_5_o, payload_6_o, payload_7_o};
    if (frames_due.size() == 0) begin
      report_mismatch("unexpected frame, length", payload_length_o, 0);
    end else begin
      want = frames_due.pop_front();
      if (crc_match_o !== want.crc_match)
        report_mismatch("crc_match", crc_match_o, want.crc_match);
      if (payload_length_o !== want.length)
        report_mismatch("payload_length", payload_length_o, want.length);
      for (int k = 0; k < PAYLOAD_SLOTS; k++) begin
        if (got[k] !== want.payload[k])
          report_mismatch($sformatf("payload_%0d", k), got[k], want.payload[k]);
      end
    end
    frames_seen++;
  endtask

  // sample both channels on the rising edge, before the block updates
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker           = MARKER_RESET;
      phase            = PH_HUNT;
      frame_len        = '0;
      frame_csum       = 8'h00;
      crc_acc          = CRC_INIT;
      frames_seen      = 0;
      mismatch_count_o = 0;
      for (int k = 0; k < PAYLOAD_SLOTS; k++) body[k] = 8'h00;
      frames_due.delete();
      frames_pending_o <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_frame();
      if (cfg_we_i) marker = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) take_beat(rx_byte_i);
      frames_pending_o <= frames_due.size();
    end
  end

endmodule

// File: verif/crc8_checked_frame_receiver_tb.sv
// crc8_checked_frame_receiver_tb: drives framed rx beats, marker writes and frame stalls
// into the crc-8 frame receiver; checking is done by crc8_frame_checker
// depends on cfr_pkg, crc8_checked_frame_receiver, crc8_frame_checker
module crc8_checked_frame_receiver_tb;
  import cfr_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 6;
  localparam int BEATS_PER_SET = 350;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       idling_on = 1'b1;

  logic       in_stall;
  logic       out_valid;
  logic       crc_match;
  logic [3:0] payload_length;
  logic [7:0] payload_0, payload_1, payload_2, payload_3;
  logic [7:0] payload_4, payload_5, payload_6, payload_7;
  int         mismatch_count;
  int         frames_pending;

  logic [7:0] cur_marker = MARKER_RESET;
  logic [7:0] frame_body [$];
  int         frame_beats;
  int         cycles;
  logic [7:0] marker_set [4];

  crc8_checked_frame_receiver u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .crc_match_o      (crc_match),
    .payload_length_o (payload_length),
    .payload_0_o      (payload_0),
    .payload_1_o      (payload_1),
    .payload_2_o      (payload_2),
    .payload_3_o      (payload_3),
    .payload_4_o      (payload_4),
    .payload_5_o      (payload_5),
    .payload_6_o      (payload_6),
    .payload_7_o      (payload_7)
  );

  crc8_frame_checker u_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .crc_match_o      (crc_match),
    .payload_length_o (payload_length),
    .payload_0_o      (payload_0),
    .payload_1_o      (payload_1),
    .payload_2_o      (payload_2),
    .payload_3_o      (payload_3),
    .payload_4_o      (payload_4),
    .payload_5_o      (payload_5),
    .payload_6_o      (payload_6),
    .payload_7_o      (payload_7),
    .mismatch_count_o (mismatch_count),
    .frames_pending_o (frames_pending)
  );

  always #5 clk_i = ~clk_i;

  // random frame stalls while idling is on
  always @(posedge clk_i) begin
    out_stall <= rst_ni && idling_on && ($urandom_range(99) < 8);
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // checksum the sender puts in front of frame_body
  function automatic logic [7:0] body_checksum();
    logic [7:0] r;
    r = CRC_INIT;
    foreach (frame_body[j]) begin
      for (int i = 0; i < 8; i++) begin
        r = (r >> 1) ^ ((r[0] ^ frame_body[j][i]) ? CRC_POLY : 8'h00);
      end
    end
    return r;
  endfunction

  // one rx beat, occasionally preceded by an idle with in_valid low
  task automatic push_byte(input logic [7:0] b);
    if (idling_on && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // marker, length, then, if the length is legal, checksum and body_count beats of frame_body
  task automatic send_frame(input logic [7:0] len_byte, input int body_count,
                            input bit bad_sum);
    logic [7:0] sum;
    sum = body_checksum();
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    push_byte(cur_marker);
    push_byte(len_byte);
    frame_beats += 2;
    if (len_byte <= DEF_MAX_PAYLOAD) begin
      push_byte(sum);
      frame_beats++;
      for (int i = 0; i < body_count; i++) begin
        push_byte(frame_body[i]);
        frame_beats++;
      end
    end
  endtask

  // fill frame_body with random bytes, some equal to the marker
  task automatic random_body(input int len);
    frame_body.delete();
    for (int i = 0; i < len; i++) begin
      frame_body.push_back(($urandom_range(7) == 0) ? cur_marker : 8'($urandom_range(255)));
    end
  endtask

  // wait until every predicted frame is out and the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (frames_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_marker(input logic [7:0] m);
    cfg_we     <= 1'b1;
    cfg_wdata  <= m;
    cur_marker = m;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed frames, plus oversized, cut-short and stray beats
  task automatic random_traffic(input int target);
    int r;
    int len;
    frame_beats = 0;
    while (frame_beats < target) begin
      r = $urandom_range(99);
      if (r < 72) begin
        len = $urandom_range(0, DEF_MAX_PAYLOAD);
        random_body(len);
        send_frame(8'(len), len, $urandom_range(3) == 0);
      end else if (r < 82) begin
        frame_body.delete();
        send_frame(8'($urandom_range(DEF_MAX_PAYLOAD + 1, 255)), 0, 1'b0);
      end else if (r < 90) begin
        len = $urandom_range(1, DEF_MAX_PAYLOAD);
        random_body(len);
        send_frame(8'(len), $urandom_range(0, len - 1), 1'b0);
      end else begin
        push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset marker, stray beat, empty frames, size extremes, marker in body
    push_byte(8'h00);
    frame_body.delete();
    send_frame(8'h00, 0, 1'b0);
    frame_body.delete();
    frame_body.push_back(8'h00);
    frame_body.delete();
    push_byte(cur_marker);
    push_byte(8'h00);
    push_byte(8'h5A);
    send_frame(8'(DEF_MAX_PAYLOAD + 1), 0, 1'b0);
    frame_body = '{8'hFF, 8'h00, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55};
    send_frame(8'(DEF_MAX_PAYLOAD), DEF_MAX_PAYLOAD, 1'b0);
    frame_body = '{8'h3C};
    send_frame(8'h01, 1, 1'b1);
    frame_body.delete();
    send_frame(8'hFF, 0, 1'b0);
    drain();

    // random traffic over several markers, one set without any idling
    marker_set = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), MARKER_RESET};
    for (int p = 0; p < 4; p++) begin
      write_marker(marker_set[p]);
      idling_on <= (p != 1);
      random_traffic(BEATS_PER_SET);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
